// ===== hdl/rhp_pkg.sv =====
// Shared types and constants for the RTP fixed-header parser.
// No dependencies; imported by every module of the block.
package rhp_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int HEADER_BYTES     = 12;
  localparam int QUEUE_DEPTH      = 2;

  localparam int SAMPLE_BITS_W = 6;
  localparam int CHANNEL_W     = 5;
  localparam int RATE_W        = 18;
  localparam int PLEN_W        = 12;
  localparam int DUR_W         = 18;
  localparam int US_W          = 20;
  localparam int CFG_IDX_W     = 2;

  localparam logic [US_W-1:0]  US_PER_SEC   = 20'd1000000;
  localparam logic [DUR_W-1:0] DURATION_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_CSRC     = 2'd2,
    ST_OVERSIZE = 2'd3
  } rhp_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_BITS = 2'd0,
    CFG_CHANNELS    = 2'd1,
    CFG_RATE        = 2'd2
  } rhp_cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_BPS,
    BK_DIV_CC,
    BK_MUL,
    BK_DIV_RATE,
    BK_DONE
  } rhp_back_state_e;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
  } rhp_hdr_t;

  typedef struct packed {
    logic [SAMPLE_BITS_W-1:0] sample_bits;
    logic [CHANNEL_W-1:0]     num_channels;
    logic [RATE_W-1:0]        frame_rate;
  } rhp_cfg_t;

  typedef struct packed {
    logic [1:0]        version;
    logic              padding;
    logic              extension;
    logic [3:0]        csrc_cnt;
    logic              marker;
    logic [6:0]        pay_type;
    logic [15:0]       sequence_res;
    logic [31:0]       timestamp;
    logic [31:0]       ssrc;
    logic [PLEN_W-1:0] pay_len;
    logic [DUR_W-1:0]  duration_us;
    rhp_status_e       status;
  } rhp_result_t;

endpackage

// ===== hdl/rhp_front.sv =====
// Byte capture front end: collects the 12-byte fixed header and counts length.
// Depends on rhp_pkg. Emits one job per packet at the last byte.
module rhp_front import rhp_pkg::*; #(
  parameter  int MaxPacketBytes = MAX_PACKET_BYTES,
  localparam int LenW           = $clog2(MaxPacketBytes + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  output logic            push_o,
  output rhp_hdr_t        hdr_o,
  output logic [LenW-1:0] len_o,
  output logic            over_o
);

  logic [LenW-1:0] count_q, count_d;
  rhp_hdr_t        hdr_q, hdr_d;
  logic            over_q, over_d;
  logic [4:0]      lane_sh;

  always_comb begin
    hdr_d   = hdr_q;
    count_d = count_q;
    over_d  = over_q;
    lane_sh = {2'd3 - count_q[1:0], 3'b000};
    push_o  = 1'b0;
    hdr_o   = hdr_q;
    len_o   = count_q;
    over_o  = over_q;
    if (accept_i) begin
      if (count_q < LenW'(HEADER_BYTES)) begin
        case (count_q[3:2])
          2'd0:    hdr_d.first_word[lane_sh +: 8] = data_byte_i;
          2'd1:    hdr_d.timestamp[lane_sh +: 8]  = data_byte_i;
          default: hdr_d.ssrc[lane_sh +: 8]       = data_byte_i;
        endcase
      end
      if (count_q < LenW'(MaxPacketBytes)) begin
        count_d = count_q + 1'b1;
      end else begin
        over_d = 1'b1;
      end
      // job carries this byte's update
      hdr_o  = hdr_d;
      len_o  = count_d;
      over_o = over_d;
      if (last_byte_i) begin
        push_o  = 1'b1;
        hdr_d   = '0;
        count_d = '0;
        over_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hdr_q   <= '0;
      over_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      hdr_q   <= hdr_d;
      over_q  <= over_d;
    end
  end

endmodule

// ===== hdl/rhp_fifo.sv =====
// Small register queue between the capture front end and the compute back end.
// Depends on rhp_pkg for the default depth.
module rhp_fifo import rhp_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rhp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rhp_pkg (house import). Shared by all three divisions.
module rhp_div import rhp_pkg::*; #(
  parameter int DividendW = 32,
  parameter int DivisorW  = RATE_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int CntW = $clog2(DividendW);

  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  rem_q, dvs_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    shifted, diff;
  logic                 ge;

  assign shifted    = {rem_q, quo_q[DividendW-1]};
  assign diff       = shifted - {1'b0, dvs_q};
  assign ge         = ~diff[DivisorW];
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
      quo_q <= {quo_q[DividendW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/rhp_back.sv =====
// Compute back end: status, payload length, duration, and the result register.
// Depends on rhp_pkg and rhp_div.
module rhp_back import rhp_pkg::*; #(
  parameter  int MaxPacketBytes = MAX_PACKET_BYTES,
  localparam int LenW           = $clog2(MaxPacketBytes + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  rhp_hdr_t        hdr_i,
  input  logic [LenW-1:0] len_i,
  input  logic            over_i,
  input  rhp_cfg_t        cfg_i,
  output logic            pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output rhp_result_t     result_o
);

  localparam int HdrW = (LenW > 7) ? LenW : 7;
  localparam int DivW = LenW + US_W;

  rhp_back_state_e state_q, state_d;
  rhp_hdr_t        hdr_q;
  rhp_status_e     status_q, status_new;
  logic [LenW-1:0] plen_q, plen_new;
  logic [DivW-1:0] mul_q;
  logic [DUR_W-1:0] dur_q;
  rhp_result_t     out_q;
  logic            out_valid_q;

  logic [HdrW-1:0] len_x, hdr_len;
  logic [2:0]      bps;
  logic            div_ok, go_calc;

  logic            div_start, div_done;
  logic [DivW-1:0] div_dividend, div_quo;
  logic [RATE_W-1:0] div_divisor;
  logic            capture, mul_en, dur_en, load;

  // head-of-queue decode
  always_comb begin
    len_x   = HdrW'(len_i);
    hdr_len = HdrW'(HEADER_BYTES) + HdrW'({hdr_i.first_word[27:24], 2'b00});
    if (over_i) begin
      status_new = ST_OVERSIZE;
    end else if (len_x <= HdrW'(HEADER_BYTES)) begin
      status_new = ST_SHORT;
    end else if (hdr_len > len_x) begin
      status_new = ST_CSRC;
    end else begin
      status_new = ST_OK;
    end
    plen_new = LenW'(len_x - hdr_len);
    bps      = cfg_i.sample_bits[5:3];
    div_ok   = (bps != '0) && (cfg_i.num_channels != '0) && (cfg_i.frame_rate != '0);
    go_calc  = (status_new == ST_OK) && div_ok;
  end

  rhp_div #(
    .DividendW(DivW),
    .DivisorW (RATE_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = go_calc ? BK_DIV_BPS : BK_DONE;
        end
      end
      BK_DIV_BPS: begin
        if (div_done) state_d = BK_DIV_CC;
      end
      BK_DIV_CC: begin
        if (div_done) state_d = BK_MUL;
      end
      BK_MUL:      state_d = BK_DIV_RATE;
      BK_DIV_RATE: begin
        if (div_done) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = BK_IDLE;
      end
      default:     state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o        = 1'b0;
    capture      = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_en       = 1'b0;
    dur_en       = 1'b0;
    load         = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          pop_o        = 1'b1;
          capture      = 1'b1;
          div_start    = go_calc;
          div_dividend = DivW'(plen_new);
          div_divisor  = RATE_W'(bps);
        end
      end
      BK_DIV_BPS: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quo;
          div_divisor  = RATE_W'(cfg_i.num_channels);
        end
      end
      BK_DIV_CC: begin
        mul_en = div_done;
      end
      BK_MUL: begin
        div_start    = 1'b1;
        div_dividend = mul_q;
        div_divisor  = cfg_i.frame_rate;
      end
      BK_DIV_RATE: begin
        dur_en = div_done;
      end
      BK_DONE: begin
        load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      hdr_q    <= hdr_i;
      status_q <= status_new;
      plen_q   <= (status_new == ST_OK) ? plen_new : '0;
      dur_q    <= '0;
    end
    if (mul_en) begin
      mul_q <= DivW'(div_quo[LenW-1:0]) * DivW'(US_PER_SEC);
    end
    if (dur_en) begin
      dur_q <= (div_quo > DivW'(DURATION_MAX)) ? DURATION_MAX : div_quo[DUR_W-1:0];
    end
    if (load) begin
      out_q.version      <= hdr_q.first_word[31:30];
      out_q.padding      <= hdr_q.first_word[29];
      out_q.extension    <= hdr_q.first_word[28];
      out_q.csrc_cnt     <= hdr_q.first_word[27:24];
      out_q.marker       <= hdr_q.first_word[23];
      out_q.pay_type     <= hdr_q.first_word[22:16];
      out_q.sequence_res <= hdr_q.first_word[15:0];
      out_q.timestamp    <= hdr_q.timestamp;
      out_q.ssrc         <= hdr_q.ssrc;
      out_q.pay_len      <= PLEN_W'(plen_q);
      out_q.duration_us  <= dur_q;
      out_q.status       <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

// ===== hdl/rtp_header_parse_duration.sv =====
// RTP fixed-header parser with payload duration; top level (rhp_pkg, front, fifo, back).
// Input: one byte per cycle, never stalled unless both queue entries hold finished packets.
// Bad status or zero divisors skip the divider; every other packet waits on the bit-serial
//   divider doing three divisions in a row, and the back end takes no new packet
//   until the current one is loaded into the result register.
// Reset (async, active low) clears the byte counter, queue, sequencer and config to 16/2/48000.
module rtp_header_parse_duration import rhp_pkg::*; #(
  parameter int MaxPacketBytes = MAX_PACKET_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  // byte stream in
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  // result word out
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           version_o,
  output logic                 padding_o,
  output logic                 extension_o,
  output logic [3:0]           csrc_cnt_o,
  output logic                 marker_o,
  output logic [6:0]           pay_type_o,
  output logic [15:0]          sequence_res_o,
  output logic [31:0]          timestamp_o,
  output logic [31:0]          ssrc_o,
  output logic [PLEN_W-1:0]    pay_len_o,
  output logic [DUR_W-1:0]     duration_us_o,
  output logic [1:0]           status_o
);

  localparam int LenW = $clog2(MaxPacketBytes + 1);
  localparam int JobW = $bits(rhp_hdr_t) + 1 + LenW;

  // config registers, live into the back end (only written while idle, which the user must ensure; not enforced)
  rhp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_bits  <= SAMPLE_BITS_W'(16);
      cfg_q.num_channels <= CHANNEL_W'(2);
      cfg_q.frame_rate   <= RATE_W'(48000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_BITS: cfg_q.sample_bits  <= cfg_data_i[SAMPLE_BITS_W-1:0];
        CFG_CHANNELS:    cfg_q.num_channels <= cfg_data_i[CHANNEL_W-1:0];
        CFG_RATE:        cfg_q.frame_rate   <= cfg_data_i;
        default: ;       // unknown index: dropped
      endcase
    end
  end

  // front end: header capture and length count
  logic            accept, push;
  rhp_hdr_t        push_hdr;
  logic [LenW-1:0] push_len;
  logic            push_over;
  logic            q_full, q_empty, pop;
  logic [JobW-1:0] q_wdata, q_rdata;

  // stall only when the queue cannot take another packet job
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  rhp_front #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .push_o     (push),
    .hdr_o      (push_hdr),
    .len_o      (push_len),
    .over_o     (push_over)
  );

  assign q_wdata = {push_hdr, push_over, push_len};

  rhp_fifo #(
    .Width(JobW),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // back end: status, lengths, divider sequence, result register
  rhp_hdr_t        job_hdr;
  logic            job_over;
  logic [LenW-1:0] job_len;
  rhp_result_t     result;

  assign {job_hdr, job_over, job_len} = q_rdata;

  rhp_back #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .hdr_i      (job_hdr),
    .len_i      (job_len),
    .over_i     (job_over),
    .cfg_i      (cfg_q),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .result_o   (result)
  );

  assign version_o      = result.version;
  assign padding_o      = result.padding;
  assign extension_o    = result.extension;
  assign csrc_cnt_o     = result.csrc_cnt;
  assign marker_o       = result.marker;
  assign pay_type_o     = result.pay_type;
  assign sequence_res_o = result.sequence_res;
  assign timestamp_o    = result.timestamp;
  assign ssrc_o         = result.ssrc;
  assign pay_len_o      = result.pay_len;
  assign duration_us_o  = result.duration_us;
  assign status_o       = result.status;

endmodule

// ===== hdl/rhp_checker.sv =====
// Port-level checks on the result channel of the RTP header parser.
// Depends on rhp_pkg; bound to rtp_header_parse_duration below.
module rhp_checker import rhp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PLEN_W-1:0] pay_len_o,
  input logic [DUR_W-1:0]  duration_us_o,
  input logic [1:0]        status_o,
  input logic [15:0]       sequence_res_o,
  input logic [31:0]       timestamp_o,
  input logic [31:0]       ssrc_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(duration_us_o) && $stable(pay_len_o)
      && $stable(sequence_res_o) && $stable(timestamp_o) && $stable(ssrc_o))
    else $error("result word changed while stalled");

  // any error status zeroes length and duration
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (pay_len_o == '0) && (duration_us_o == '0))
    else $error("nonzero length or duration on error status");

  // a duration only comes from a good packet
  a_dur_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (duration_us_o != '0) |-> (status_o == ST_OK))
    else $error("duration reported on bad packet");

endmodule

bind rtp_header_parse_duration rhp_checker u_rhp_checker (.*);

// ===== test/rtp_hdr_check.sv =====
// Header-result checker for the RTP fixed-header parser: watches the config port and
// both word channels, predicts each result and compares it. Depends on rhp_pkg.
module rtp_hdr_check import rhp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           version_i,
  input  logic                 padding_i,
  input  logic                 extension_i,
  input  logic [3:0]           csrc_cnt_i,
  input  logic                 marker_i,
  input  logic [6:0]           pay_type_i,
  input  logic [15:0]          sequence_res_i,
  input  logic [31:0]          timestamp_i,
  input  logic [31:0]          ssrc_i,
  input  logic [PLEN_W-1:0]    pay_len_i,
  input  logic [DUR_W-1:0]     duration_us_i,
  input  logic [1:0]           status_i,
  output int                   fail_cnt_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers
  logic [SAMPLE_BITS_W-1:0] cur_bits;
  logic [CHANNEL_W-1:0]     cur_chans;
  logic [RATE_W-1:0]        cur_rate;

  // packet capture state
  logic [11:0] byte_cnt;
  logic [31:0] word0;
  logic [31:0] ts_word;
  logic [31:0] ssrc_word;
  logic        over_flag;

  rhp_result_t hdr_q[$];
  int          mismatch_cnt = 0;
  int          n_checked = 0;

  task automatic clear_packet();
    byte_cnt  = '0;
    word0     = '0;
    ts_word   = '0;
    ssrc_word = '0;
    over_flag = 1'b0;
  endtask

  // Capture one byte; on the last byte queue the header result it produces.
  task automatic take_byte(input logic [7:0] b, input logic last);
    rhp_result_t r;
    int          sh;
    int          len;
    int          hdr_len;
    int          plen;
    int          bps;
    int          frames;
    logic [63:0] dur;
    sh = 24 - 8 * int'(byte_cnt[1:0]);
    if (byte_cnt < 4) word0 |= 32'(b) << sh;
    else if (byte_cnt < 8) ts_word |= 32'(b) << sh;
    else if (byte_cnt < HEADER_BYTES) ssrc_word |= 32'(b) << sh;
    if (byte_cnt < MAX_PACKET_BYTES) byte_cnt++;
    else over_flag = 1'b1;
    if (last) begin
      len     = int'(byte_cnt);
      hdr_len = HEADER_BYTES + 4 * int'(word0[27:24]);
      plen    = 0;
      dur     = '0;
      if (over_flag) r.status = ST_OVERSIZE;
      else if (len <= HEADER_BYTES) r.status = ST_SHORT;
      else if (hdr_len > len) r.status = ST_CSRC;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        plen = len - hdr_len;
        bps  = int'(cur_bits) / 8;
        if (bps != 0 && cur_chans != 0 && cur_rate != 0) begin
          frames = (plen / bps) / int'(cur_chans);
          dur    = (64'(frames) * 64'd1000000) / 64'(cur_rate);
          if (dur > 64'(DURATION_MAX)) dur = 64'(DURATION_MAX);
        end
      end
      r.version      = word0[31:30];
      r.padding      = word0[29];
      r.extension    = word0[28];
      r.csrc_cnt     = word0[27:24];
      r.marker       = word0[23];
      r.pay_type     = word0[22:16];
      r.sequence_res = word0[15:0];
      r.timestamp    = ts_word;
      r.ssrc         = ssrc_word;
      r.pay_len      = PLEN_W'(plen);
      r.duration_us  = DUR_W'(dur);
      hdr_q.push_back(r);
      clear_packet();
    end
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("header %0d, %s: expected 0x%0h, got 0x%0h", n_checked, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rhp_result_t want;
    if (!rst_ni) begin
      cur_bits  = 6'd16;
      cur_chans = 5'd2;
      cur_rate  = 18'd48000;
      clear_packet();
      hdr_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_BITS: cur_bits = cfg_data_i[SAMPLE_BITS_W-1:0];
          CFG_CHANNELS:    cur_chans = cfg_data_i[CHANNEL_W-1:0];
          CFG_RATE:        cur_rate = cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (hdr_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("header word with nothing expected");
        end else begin
          want = hdr_q.pop_front();
          cmp_field("version", 32'(want.version), 32'(version_i));
          cmp_field("padding", 32'(want.padding), 32'(padding_i));
          cmp_field("extension", 32'(want.extension), 32'(extension_i));
          cmp_field("csrc_cnt", 32'(want.csrc_cnt), 32'(csrc_cnt_i));
          cmp_field("marker", 32'(want.marker), 32'(marker_i));
          cmp_field("pay_type", 32'(want.pay_type), 32'(pay_type_i));
          cmp_field("sequence_res", 32'(want.sequence_res), 32'(sequence_res_i));
          cmp_field("timestamp", want.timestamp, timestamp_i);
          cmp_field("ssrc", want.ssrc, ssrc_i);
          cmp_field("pay_len", 32'(want.pay_len), 32'(pay_len_i));
          cmp_field("duration_us", 32'(want.duration_us), 32'(duration_us_i));
          cmp_field("status", 32'(want.status), 32'(status_i));
          n_checked++;
        end
      end
      if (in_valid_i && !in_stall_i) take_byte(data_byte_i, last_byte_i);
    end
    fail_cnt_o <= mismatch_cnt;
    pending_o  <= hdr_q.size();
    checked_o  <= n_checked;
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for rtp_header_parse_duration: drives packets and register writes,
// sets the idle/stall mix per phase and prints the verdict. Needs rhp_pkg, rtp_hdr_check.
module tb;
  import rhp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Settle time after the last result: roughly the worst back-end latency
  // (three serial divides at 2048 max bytes) plus margin.
  localparam int DRAIN_CYCLES    = 150;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int N_PHASES        = 8;
  localparam int BYTES_PER_PHASE = 200;
  localparam logic [1:0] RTP_VERSION = 2'd2;
  // Index with no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [RATE_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = '0;
  logic                 last_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           version_o;
  logic                 padding_o;
  logic                 extension_o;
  logic [3:0]           csrc_cnt_o;
  logic                 marker_o;
  logic [6:0]           pay_type_o;
  logic [15:0]          sequence_res_o;
  logic [31:0]          timestamp_o;
  logic [31:0]          ssrc_o;
  logic [PLEN_W-1:0]    pay_len_o;
  logic [DUR_W-1:0]     duration_us_o;
  logic [1:0]           status_o;

  int          fail_cnt;
  int          pending;
  int          checked;
  int          send_idle_pct = 0;   // chance per cycle the byte source sits idle
  int          recv_stall_pct = 0;  // chance per cycle the result sink stalls
  int          bytes_sent = 0;
  int          packets_sent = 0;
  int unsigned cycles = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  rtp_header_parse_duration u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .version_o      (version_o),
    .padding_o      (padding_o),
    .extension_o    (extension_o),
    .csrc_cnt_o     (csrc_cnt_o),
    .marker_o       (marker_o),
    .pay_type_o     (pay_type_o),
    .sequence_res_o (sequence_res_o),
    .timestamp_o    (timestamp_o),
    .ssrc_o         (ssrc_o),
    .pay_len_o      (pay_len_o),
    .duration_us_o  (duration_us_o),
    .status_o       (status_o)
  );

  rtp_hdr_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .version_i      (version_o),
    .padding_i      (padding_o),
    .extension_i    (extension_o),
    .csrc_cnt_i     (csrc_cnt_o),
    .marker_i       (marker_o),
    .pay_type_i     (pay_type_o),
    .sequence_res_i (sequence_res_o),
    .timestamp_i    (timestamp_o),
    .ssrc_i         (ssrc_o),
    .pay_len_i      (pay_len_o),
    .duration_us_i  (duration_us_o),
    .status_i       (status_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Result sink back-pressure; redrawn every cycle so stalls land on every
  // phase of the back end's divide sequence.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("no progress: stopped after %0d cycles, %0d results still due", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one byte word and hold it until it is taken. Idle cycles go in
  // front, so valid only drops between words, never while one is stalled.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Whole packet: given first byte (version/flags/CSRC count), random rest.
  task automatic send_packet(input int len, input logic [7:0] first_b);
    for (int i = 0; i < len; i++) send_byte((i == 0) ? first_b : 8'($urandom), i == len - 1);
    packets_sent++;
  endtask

  // Register write with junk above the register width; only the low bits count.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int w);
    logic [RATE_W-1:0] mask;
    mask        = RATE_W'((64'd1 << w) - 1);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= (RATE_W'($urandom) & ~mask) | (RATE_W'(value) & mask);
    @(posedge clk_i);
  endtask

  // Idle the input, wait for every expected header, then let the back end
  // finish anything still in flight before the registers may change.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int          start_bytes;
    int          len;
    int          roll;
    int          cc_max;
    logic [7:0]  b0;
    int unsigned ph_bits;
    int unsigned ph_chans;
    int unsigned ph_rate;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values, no idling:
    //  - lone last byte: header fields beyond byte 0 read as zero, too short
    //  - four zero bytes: still too short, all-zero data
    //  - 13 bytes with version 2 and 15 CSRCs: list runs past the packet end
    send_packet(1, 8'hFF);
    send_packet(4, 8'h00);
    send_packet(13, {RTP_VERSION, 6'h0F});
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      // Register settings: both range ends, a common rate, a rate low enough
      // to saturate the duration, full-width values, then each zero divisor.
      case (p)
        0: begin ph_bits = 8;  ph_chans = 1;  ph_rate = 8000;   end
        1: begin ph_bits = 32; ph_chans = 16; ph_rate = 192000; end
        2: begin ph_bits = 24; ph_chans = 2;  ph_rate = 44100;  end
        3: begin ph_bits = 16; ph_chans = 1;  ph_rate = 100;    end
        4: begin ph_bits = 63; ph_chans = 31; ph_rate = 262143; end
        5: begin ph_bits = 7;  ph_chans = 3;  ph_rate = 48000;  end
        6: begin ph_bits = 16; ph_chans = 0;  ph_rate = 48000;  end
        default: begin ph_bits = 8; ph_chans = 2; ph_rate = 0; end
      endcase
      write_reg(CFG_SAMPLE_BITS, ph_bits, SAMPLE_BITS_W);
      write_reg(CFG_CHANNELS, ph_chans, CHANNEL_W);
      write_reg(CFG_RATE, ph_rate, RATE_W);
      write_reg(CFG_UNMAPPED, $urandom, RATE_W);
      cfg_we_i <= 1'b0;

      // Idle mix cycles through: none, source idle, sink stall, both.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase

      // One long packet, one byte past the size limit.
      if (p == 1) send_packet(MAX_PACKET_BYTES + 1, 8'($urandom));

      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < BYTES_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 10) len = $urandom_range(HEADER_BYTES, 1);
        else if (roll < 90) len = $urandom_range(100, HEADER_BYTES + 1);
        else len = $urandom_range(300, 101);
        b0 = 8'($urandom);
        if ($urandom_range(99) < 70) b0[7:6] = RTP_VERSION;
        // Mostly keep the CSRC list inside the packet so the duration path runs.
        if (len > HEADER_BYTES && $urandom_range(99) < 75) begin
          cc_max = (len - HEADER_BYTES) / 4;
          if (cc_max > 15) cc_max = 15;
          b0[3:0] = 4'($urandom_range(cc_max, 0));
        end
        send_packet(len, b0);
      end
      drain();
    end

    $display("sent %0d packets (%0d bytes) over %0d register settings and 4 idle mixes",
             packets_sent, bytes_sent, N_PHASES + 1);
    $display("checked %0d header results, %0d mismatches", checked, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
